FILE: sv/cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper package
// Shared constants, codes and the decode bundle for the cartridge mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int SYS_RAM_BYTES  = 8192;
    localparam int PAGE_BYTES     = 16384;
    localparam int CART_RAM_BANKS = 2;
    localparam int ROM_ADDR_BITS  = 20;

    localparam int SYS_IDX_W  = $clog2(SYS_RAM_BYTES);
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int CART_RAM_BYTES = CART_RAM_BANKS * PAGE_BYTES;
    localparam int CART_IDX_W = $clog2(CART_RAM_BYTES);

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 20;
    localparam int PAGE_NUM_W = ROM_ADDR_W - PAGE_BITS;

    localparam logic [ROM_ADDR_W-1:0] ROM_ADDR_MASK =
        ROM_ADDR_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    localparam logic [ADDR_W-1:0] UNPAGED_END = 16'h0400;
    localparam logic [ADDR_W-1:0] REG_FIRST   = 16'hFFFC;
    localparam logic [ADDR_W-1:0] REG_LAST    = 16'hFFFF;
    localparam logic [PAGE_NUM_W-1:0] MASK_BIG   = PAGE_NUM_W'(8'h3F);
    localparam logic [PAGE_NUM_W-1:0] MASK_SMALL = PAGE_NUM_W'(8'h1F);

    // Bus operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Mapper register selects (address bits [1:0] within 0xFFFC-0xFFFF)
    localparam logic [1:0] REG_CONTROL = 2'd0;
    localparam logic [1:0] REG_SLOT0   = 2'd1;
    localparam logic [1:0] REG_SLOT1   = 2'd2;
    localparam logic [1:0] REG_SLOT2   = 2'd3;

    // Read data source
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_SYS  = 2'd1;
    localparam logic [1:0] RD_CART = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ROM_OVER_32K = 1'b0;

    typedef struct packed {
        logic                  rom_read;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  sys_we;
        logic                  cart_we;
        logic [1:0]            rd_sel;
        logic                  reg_we;
        logic [1:0]            reg_sel;
        logic [SYS_IDX_W-1:0]  sys_idx;
        logic [CART_IDX_W-1:0] cart_idx;
    } cbm_decode_t;

endpackage

FILE: sv/cbm_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper address decode
// Splits one bus access into ROM address, RAM strobes and register writes.
// ----------------------------------------------------------------------------
module cbm_decode
(
    input  logic                          op,
    input  logic [cbm_pkg::ADDR_W-1:0]    address,
    input  logic [7:0]                    ram_control,
    input  logic [7:0]                    slot0_page,
    input  logic [7:0]                    slot1_page,
    input  logic [7:0]                    slot2_page,
    input  logic                          rom_over_32k,
    output cbm_pkg::cbm_decode_t          dec
);
    import cbm_pkg::*;

    logic [1:0]            slot;
    logic [7:0]            page;
    logic [PAGE_NUM_W-1:0] mask;
    logic [ROM_ADDR_W-1:0] paged_addr;
    logic [ROM_ADDR_W-1:0] flat_addr;
    logic                  cart_en;
    logic                  is_write;

    assign slot     = address[ADDR_W-1 -: 2];
    assign cart_en  = ram_control[3];
    assign is_write = (op == OP_WRITE);
    assign mask     = rom_over_32k ? MASK_BIG : MASK_SMALL;

    always_comb
    begin
        case (slot)
            2'd0:    page = slot0_page;
            2'd1:    page = slot1_page;
            default: page = slot2_page;
        endcase
    end

    assign paged_addr = {page[PAGE_NUM_W-1:0] & mask, address[PAGE_BITS-1:0]} & ROM_ADDR_MASK;
    assign flat_addr  = ROM_ADDR_W'(address) & ROM_ADDR_MASK;

    always_comb
    begin
        dec          = '0;
        dec.sys_idx  = address[SYS_IDX_W-1:0];
        dec.cart_idx = (CART_IDX_W'(ram_control[2]) << PAGE_BITS)
                     | CART_IDX_W'(address[PAGE_BITS-1:0]);
        dec.reg_sel  = address[1:0];
        dec.rd_sel   = RD_NONE;

        if (is_write)
        begin
            if (slot == 2'd3)
            begin
                dec.sys_we = 1'b1;
                dec.reg_we = (address >= REG_FIRST) && (address <= REG_LAST);
            end
            else if (slot == 2'd2)
            begin
                dec.cart_we = cart_en;
            end
        end
        else
        begin
            if (address < UNPAGED_END)
            begin
                dec.rom_read    = 1'b1;
                dec.rom_address = flat_addr;
            end
            else if (slot == 2'd3)
            begin
                dec.rd_sel = RD_SYS;
            end
            else if (slot == 2'd2 && cart_en)
            begin
                dec.rd_sel = RD_CART;
            end
            else
            begin
                dec.rom_read    = 1'b1;
                dec.rom_address = paged_addr;
            end
        end
    end

endmodule

FILE: sv/console_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console bank mapper
// Three-slot ROM paging, cartridge RAM and mirrored system RAM for a CPU bus.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, op, address, write_data) carries one
//   bus transaction; output channel (out_valid / out_stall, read_data,
//   rom_read, rom_address) returns exactly one result per transaction.
//   A ROM read is not served here: rom_read = 1 with the physical ROM address
//   tells the host to fetch from external ROM.
//   out_valid rises in the cycle after acceptance. Throughput is one
//   transaction per cycle unless the receiver stalls: decode, register
//   update and the single RAM port access all happen at the accepting clock edge.
//   When the receiver stalls, the result register holds and in_stall rises
//   so no further transaction is taken until the result drains.
//   Reset (rst_n low) clears the output valid, sets the page registers to
//   0/1/2, ram_control to 0 and rom_over_32k to 1. RAM contents are not
//   cleared; reads of unwritten locations return arbitrary data.
//   rom_over_32k is written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module console_bank_mapper
(
    input  logic                               clk,
    input  logic                               rst_n,
    // bus transaction in
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [cbm_pkg::ADDR_W-1:0]         address,
    input  logic [cbm_pkg::DATA_W-1:0]         write_data,
    // result out
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cbm_pkg::DATA_W-1:0]         read_data,
    output logic                               rom_read,
    output logic [cbm_pkg::ROM_ADDR_W-1:0]     rom_address,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import cbm_pkg::*;

    // Mapper registers
    logic [7:0] ram_control_reg;
    logic [7:0] slot0_page_reg;
    logic [7:0] slot1_page_reg;
    logic [7:0] slot2_page_reg;
    logic       rom_over_32k_reg;

    // Result stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            rd_sel_reg;
    logic                  rom_read_reg;
    logic [ROM_ADDR_W-1:0] rom_address_reg;
    logic [DATA_W-1:0]     sys_rd_reg;
    logic [DATA_W-1:0]     cart_rd_reg;

    // RAM arrays
    logic [DATA_W-1:0] sys_ram  [SYS_RAM_BYTES];
    logic [DATA_W-1:0] cart_ram [CART_RAM_BYTES];

    logic        in_accept;
    logic        cfg_write;
    cbm_decode_t dec;

    // Hold off new transactions only while a finished result waits.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    cbm_decode u_decode
    (
        .op           (op),
        .address      (address),
        .ram_control  (ram_control_reg),
        .slot0_page   (slot0_page_reg),
        .slot1_page   (slot1_page_reg),
        .slot2_page   (slot2_page_reg),
        .rom_over_32k (rom_over_32k_reg),
        .dec          (dec)
    );

    // Configuration port: single register at word 0, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == CFG_ROM_OVER_32K) ? {31'd0, rom_over_32k_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_over_32k_reg <= 1'b1;
        end
        else if (cfg_write && paddr[2] == CFG_ROM_OVER_32K)
        begin
            rom_over_32k_reg <= pwdata[0];
        end
    end

    // Paging registers: load on writes to 0xFFFC-0xFFFF.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_control_reg <= 8'd0;
            slot0_page_reg  <= 8'd0;
            slot1_page_reg  <= 8'd1;
            slot2_page_reg  <= 8'd2;
        end
        else if (in_accept && dec.reg_we)
        begin
            case (dec.reg_sel)
                REG_CONTROL: ram_control_reg <= write_data;
                REG_SLOT0:   slot0_page_reg  <= write_data;
                REG_SLOT1:   slot1_page_reg  <= write_data;
                REG_SLOT2:   slot2_page_reg  <= write_data;
                default:     ram_control_reg <= ram_control_reg;
            endcase
        end
    end

    // System RAM: one access per transaction, read data captured on accept.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (dec.sys_we)
            begin
                sys_ram[dec.sys_idx] <= write_data;
            end
            if (dec.rd_sel == RD_SYS)
            begin
                sys_rd_reg <= sys_ram[dec.sys_idx];
            end
        end
    end

    // Cartridge RAM, banked by ram_control bit 2.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (dec.cart_we)
            begin
                cart_ram[dec.cart_idx] <= write_data;
            end
            if (dec.rd_sel == RD_CART)
            begin
                cart_rd_reg <= cart_ram[dec.cart_idx];
            end
        end
    end

    // Result register: advance on accept, drop valid once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rd_sel_reg    <= RD_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                rd_sel_reg <= dec.rd_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rom_read_reg    <= dec.rom_read;
            rom_address_reg <= dec.rom_address;
        end
    end

    // Select the captured RAM byte; zero for writes and ROM reads.
    always_comb
    begin
        case (rd_sel_reg)
            RD_SYS:  read_data = sys_rd_reg;
            RD_CART: read_data = cart_rd_reg;
            default: read_data = '0;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign rom_read    = rom_read_reg;
    assign rom_address = rom_address_reg;

endmodule
